// ===== hw/rtl/bucketed_hash_table_top_macros.svh =====
// Assertion macros used by the checker file bht_checker.sv.
// Depends on nothing; include once per file that asserts.
`ifndef BUCKETED_HASH_TABLE_TOP_MACROS_SVH
`define BUCKETED_HASH_TABLE_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BHT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bucketed_hash_table: %s failed", "label");

// Implication whose consequence is checked in the cycle after the antecedent.
`define BHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bucketed_hash_table: %s failed", "label");

`endif

// ===== hw/rtl/bht_pkg.sv =====
// Types and constants for the bucketed hash table.
// Used by every module of the block; depends on nothing.
package bht_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_UPDATE   = 3'd1,
        CMD_GET      = 3'd2,
        CMD_CONTAINS = 3'd3,
        CMD_REMOVE   = 3'd4
    } bht_cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } bht_status_t;

    localparam int unsigned COUNT_W = 11;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] lookup_key;
        logic [63:0] value_in;
    } bht_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [63:0]        value_out;
        logic [COUNT_W-1:0] entry_count;
    } bht_rsp_t;

    // Back-end execution states.
    typedef enum logic [1:0] {
        EX_IDLE,
        EX_READ,
        EX_WRITE,
        EX_RESP
    } bht_ex_state_t;

endpackage

// ===== hw/rtl/bht_front.sv =====
// Front end: accept requests and hold them in a two-entry queue.
// Depends on bht_pkg.
module bht_front
    import bht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  bht_req_t in_req,
    output logic     q_valid,
    input  logic     q_ready,
    output bht_req_t q_req
);

    bht_req_t  entry_reg [2];
    logic      wr_ptr_reg, wr_ptr_next;
    logic      rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic      push, pop;

    assign in_ready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_req    = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Advance pointers and fill level.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the incoming request.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

// ===== hw/rtl/bht_back.sv =====
// Back end: bucket read, way compare, write-back and response register.
// Depends on bht_pkg.
module bht_back
    import bht_pkg::*;
#(
    parameter int unsigned BUCKETS = 256,
    parameter int unsigned WAYS    = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    output logic     q_ready,
    input  bht_req_t q_req,
    output logic     out_valid,
    input  logic     out_ready,
    output bht_rsp_t out_rsp
);

    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    // Key/value/valid memories, one row per bucket.
    logic [WAYS*64-1:0] key_mem   [BUCKETS];
    logic [WAYS*64-1:0] val_mem   [BUCKETS];
    logic [WAYS-1:0]    valid_mem [BUCKETS];

    bht_ex_state_t      state_reg, state_next;
    bht_req_t           req_reg;
    logic [BW-1:0]      bucket;
    logic [WAYS*64-1:0] key_row_reg, val_row_reg;
    logic [WAYS-1:0]    vrow_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    bht_rsp_t           rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               clr_busy_reg, clr_busy_next;
    logic [BW-1:0]      clr_idx_reg, clr_idx_next;
    logic               load, do_write, set_v, clr_v;
    logic [WAYS*64-1:0] val_row_new;
    logic [WAYS-1:0]    vrow_new;
    logic [WAYS-1:0]    hit_vec, free_vec;
    logic [WW-1:0]      hit_way, free_way;
    logic               found, has_free;

    assign bucket    = req_reg.lookup_key[BW-1:0];
    assign out_valid = rsp_valid_reg;
    assign out_rsp   = rsp_reg;
    assign q_ready   = (state_reg == EX_IDLE) && !rsp_valid_reg && !clr_busy_reg;
    assign load      = q_valid && q_ready;

    // Walk every bucket once after reset to clear its valid bits.
    assign clr_idx_next  = clr_idx_reg + 1'b1;
    assign clr_busy_next = clr_busy_reg && (clr_idx_reg != BW'(BUCKETS - 1));

    // Compare all ways in parallel.
    always_comb
    begin
        hit_vec  = '0;
        free_vec = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w]  = vrow_reg[w] && (key_row_reg[w*64 +: 64] == req_reg.lookup_key);
            free_vec[w] = !vrow_reg[w];
        end
        found    = |hit_vec;
        has_free = |free_vec;
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WW'(w);
            end
            if (free_vec[w])
            begin
                free_way = WW'(w);
            end
        end
    end

    // Decide the command outcome and the write-back.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        do_write       = 1'b0;
        set_v          = 1'b0;
        clr_v          = 1'b0;
        val_row_new    = val_row_reg;
        vrow_new       = vrow_reg;
        if (rsp_valid_reg && out_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            EX_IDLE:
            begin
                if (load)
                begin
                    state_next = EX_READ;
                end
            end
            EX_READ:
            begin
                state_next = EX_WRITE;
            end
            EX_WRITE:
            begin
                rsp_next.status    = ST_NOT_FOUND;
                rsp_next.value_out = '0;
                unique case (req_reg.cmd)
                    CMD_INSERT:
                    begin
                        if (found)
                        begin
                            rsp_next.status = ST_DUPLICATE;
                        end
                        else if (!has_free)
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            rsp_next.status = ST_OK;
                            do_write = 1'b1;
                            set_v    = 1'b1;
                            vrow_new[free_way] = 1'b1;
                            val_row_new[free_way*64 +: 64] = req_reg.value_in;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_UPDATE:
                    begin
                        if (found)
                        begin
                            rsp_next.status = ST_OK;
                            do_write = 1'b1;
                            val_row_new[hit_way*64 +: 64] = req_reg.value_in;
                        end
                    end
                    CMD_GET, CMD_CONTAINS:
                    begin
                        if (found)
                        begin
                            rsp_next.status = ST_OK;
                            if (req_reg.cmd == CMD_GET)
                            begin
                                rsp_next.value_out = val_row_reg[hit_way*64 +: 64];
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (found)
                        begin
                            rsp_next.status    = ST_OK;
                            rsp_next.value_out = val_row_reg[hit_way*64 +: 64];
                            clr_v = 1'b1;
                            vrow_new[hit_way] = 1'b0;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                rsp_next.entry_count = count_next;
                rsp_valid_next       = 1'b1;
                state_next           = EX_RESP;
            end
            EX_RESP:
            begin
                state_next = EX_IDLE;
            end
            default:
            begin
                state_next = EX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EX_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            clr_busy_reg  <= clr_busy_next;
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_next;
            end
        end
    end

    // Hold the request, read the bucket row, write back the data row.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (load)
        begin
            req_reg <= q_req;
        end
        if (state_reg == EX_READ)
        begin
            key_row_reg <= key_mem[bucket];
            val_row_reg <= val_mem[bucket];
            vrow_reg    <= valid_mem[bucket];
        end
        if (do_write)
        begin
            val_mem[bucket] <= val_row_new;
        end
        if (set_v)
        begin
            key_mem[bucket][free_way*64 +: 64] <= req_reg.lookup_key;
        end
        if (clr_busy_reg)
        begin
            valid_mem[clr_idx_reg] <= '0;
        end
        else if (set_v || clr_v)
        begin
            valid_mem[bucket] <= vrow_new;
        end
    end

endmodule

// ===== hw/rtl/bucketed_hash_table_top.sv =====
// Bucketed hash table: 64-bit keys and data, BUCKETS x WAYS slots, identity hash.
// A request enters a two-entry queue; the back end takes it in the idle state, reads its
// bucket row in the read state, compares all ways and writes back in the write state,
// and registers the response there; it takes no new request until that response has
// been accepted, so a response left waiting holds the back end. After reset the
// valid bits are cleared one bucket per cycle, and no request enters the back end
// until that pass ends.
// Depends on bht_pkg, bht_front, bht_back.
module bucketed_hash_table_top
    import bht_pkg::*;
#(
    parameter int unsigned BUCKETS = 256,
    parameter int unsigned WAYS    = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  bht_req_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output bht_rsp_t out_data
);

    logic     q_valid, q_ready;
    bht_req_t q_req;

    bht_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_req   (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    bht_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_data)
    );

endmodule

// ===== hw/rtl/bht_checker.sv =====
// Port-level checks for the bucketed hash table, bound to the top level.
// Depends on bht_pkg and the assertion macro header.
`include "bucketed_hash_table_top_macros.svh"

module bht_checker
    import bht_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input bht_req_t in_data,
    input logic     out_valid,
    input logic     out_ready,
    input bht_rsp_t out_data
);

    `BHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `BHT_ASSERT_IMPL(a_found_data, clk, rst_n, out_valid && out_data.status != ST_OK, out_data.value_out == 64'd0)
    `BHT_ASSERT_NEXT(a_count_step, clk, rst_n, out_valid && out_ready, !out_valid || ($past(out_data.entry_count) == out_data.entry_count) || ($past(out_data.entry_count) + 11'd1 == out_data.entry_count) || ($past(out_data.entry_count) - 11'd1 == out_data.entry_count))
    `BHT_ASSERT_NEXT(a_no_back, clk, rst_n, out_valid && out_ready, !out_valid)

endmodule

bind bucketed_hash_table_top bht_checker u_bht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
